// ===== rtl/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 to code point decoder.
// No dependencies; imported by u8dec_core and utf8_to_codepoint_decoder.
package u8dec_pkg;

  localparam int CP_W  = 21;
  localparam int LEN_W = 3;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Prefix patterns of the byte classes
  localparam logic [1:0] CONT_PFX  = 2'b10;
  localparam logic [2:0] LEAD2_PFX = 3'b110;
  localparam logic [3:0] LEAD3_PFX = 4'b1110;
  localparam logic [4:0] LEAD4_PFX = 5'b11110;

  localparam logic [LEN_W-1:0] LEN_1 = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4 = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_bytes;
    logic             malformed;
  } result_t;

endpackage

// ===== rtl/u8dec_in_reg.sv =====
// Input register of the UTF-8 decoder: holds one byte beat and its end flag.
// Standalone; the advance signal comes from the top level.
module u8dec_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  logic accept;

  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= in_byte;
      held_last <= end_of_text;
    end
  end

`ifndef NO_ASSERTIONS
  a_adv_needs_item: assert property (@(posedge clk) disable iff (rst)
    advance |-> held_valid)
    else $error("advance without a held beat");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> held_valid)
    else $error("input stalled while register empty");

  a_held_kept: assert property (@(posedge clk) disable iff (rst)
    held_valid && !advance |=> held_valid && $stable(held_byte) && $stable(held_last))
    else $error("held beat lost or changed before advance");
`endif

endmodule

// ===== rtl/u8dec_core.sv =====
// Sequence state and combinational decode step of the UTF-8 decoder.
// Depends on u8dec_pkg for result_t and byte class constants.
module u8dec_core
  import u8dec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       last,
  output logic       emit,
  output result_t    res
);

  logic [1:0]       bytes_left, bytes_left_next;
  logic [LEN_W-1:0] seq_length, seq_length_next;
  logic [CP_W-1:0]  accum, accum_next;
  logic             bad_seen, bad_seen_next;

  logic             bad_acc;
  logic [CP_W-1:0]  acc_shift;
  logic [1:0]       left_dec;

  assign bad_acc   = bad_seen || (byte_in[7:6] != CONT_PFX);
  assign acc_shift = {accum[CP_W-7:0], byte_in[5:0]};
  assign left_dec  = bytes_left - 2'd1;

  always_comb begin
    emit            = 1'b0;
    res             = '{code_point: REPLACEMENT_CP, seq_bytes: LEN_1, malformed: 1'b1};
    bytes_left_next = bytes_left;
    seq_length_next = seq_length;
    accum_next      = accum;
    bad_seen_next   = bad_seen;
    if (bytes_left != 2'd0) begin
      bytes_left_next = left_dec;
      accum_next      = acc_shift;
      bad_seen_next   = bad_acc;
      if (left_dec == 2'd0) begin
        emit = 1'b1;
        res  = '{code_point: bad_acc ? REPLACEMENT_CP : acc_shift,
                 seq_bytes: seq_length, malformed: bad_acc};
      end else if (last) begin
        emit = 1'b1;
        res  = '{code_point: REPLACEMENT_CP, seq_bytes: seq_length, malformed: 1'b1};
      end
    end else if (byte_in[7:3] == LEAD4_PFX) begin
      bytes_left_next = 2'd3;
      seq_length_next = LEN_4;
      accum_next      = {{(CP_W-3){1'b0}}, byte_in[2:0]};
      bad_seen_next   = 1'b0;
      emit            = last;
      res.seq_bytes   = LEN_4;
    end else if (byte_in[7:4] == LEAD3_PFX) begin
      bytes_left_next = 2'd2;
      seq_length_next = LEN_3;
      accum_next      = {{(CP_W-4){1'b0}}, byte_in[3:0]};
      bad_seen_next   = 1'b0;
      emit            = last;
      res.seq_bytes   = LEN_3;
    end else if (byte_in[7:5] == LEAD2_PFX) begin
      bytes_left_next = 2'd1;
      seq_length_next = LEN_2;
      accum_next      = {{(CP_W-5){1'b0}}, byte_in[4:0]};
      bad_seen_next   = 1'b0;
      emit            = last;
      res.seq_bytes   = LEN_2;
    end else if (!byte_in[7]) begin
      emit = 1'b1;
      res  = '{code_point: {{(CP_W-8){1'b0}}, byte_in}, seq_bytes: LEN_1, malformed: 1'b0};
    end else begin
      // stray continuation or invalid lead
      emit = 1'b1;
    end
    // any emitted result or end of string drops back to idle
    if (emit || last) begin
      bytes_left_next = 2'd0;
      seq_length_next = '0;
      accum_next      = '0;
      bad_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 2'd0;
      seq_length <= '0;
      accum      <= '0;
      bad_seen   <= 1'b0;
    end else if (step) begin
      bytes_left <= bytes_left_next;
      seq_length <= seq_length_next;
      accum      <= accum_next;
      bad_seen   <= bad_seen_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_len_consistent: assert property (@(posedge clk) disable iff (rst)
    bytes_left != 2'd0 |-> seq_length >= LEN_2 && {1'b0, bytes_left} < seq_length)
    else $error("bytes_left inconsistent with claimed length");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    step && (emit || last) |=> bytes_left == 2'd0)
    else $error("decoder not idle after result or end of string");

  a_good_single: assert property (@(posedge clk) disable iff (rst)
    emit && !res.malformed && res.seq_bytes == LEN_1 |-> res.code_point < 21'h80)
    else $error("single-byte result above ASCII range");
`endif

endmodule

// ===== rtl/utf8_to_codepoint_decoder.sv =====
// Top level of the lenient UTF-8 to code point decoder.
// Depends on u8dec_pkg, u8dec_in_reg and u8dec_core.
//
// Input channel: in_valid/in_stall carry one byte beat (in_byte) plus
// end_of_text on the last byte of a string. Output channel:
// out_valid/out_stall carry one code point beat (code_point, seq_bytes,
// malformed) each time a sequence ends; bytes inside a sequence give none.
// A result is written to the result register when the byte that ends its
// sequence passes from the input register through the decode step.
// Throughput: one byte per cycle unless held by a stalled result; the decode
// step is a shift-or and a few prefix compares between the two registers.
// A held result stalls the decoder only when the next byte also ends a
// sequence; bytes that give no result keep flowing past it.
// Reset (rst, synchronous): both registers empty, decoder idle awaiting a
// lead byte. Malformed input gives U+FFFD with malformed set; end_of_text
// always returns the decoder to idle.
module utf8_to_codepoint_decoder
  import u8dec_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             end_of_text,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CP_W-1:0]  code_point,
  output logic [LEN_W-1:0] seq_bytes,
  output logic             malformed
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       advance;
  logic       emit;
  logic       out_free;
  result_t    res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = held_valid && (!emit || out_free);

  u8dec_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .advance     (advance),
    .held_valid  (held_valid),
    .held_byte   (held_byte),
    .held_last   (held_last)
  );

  u8dec_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (held_byte),
    .last    (held_last),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      code_point <= res.code_point;
      seq_bytes  <= res.seq_bytes;
      malformed  <= res.malformed;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance && emit |-> out_free)
    else $error("result register overwritten while stalled");

  a_new_result: assert property (@(posedge clk) disable iff (rst)
    advance && emit |=> out_valid)
    else $error("emitted result not presented");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> seq_bytes >= LEN_1 && seq_bytes <= LEN_4)
    else $error("sequence length out of range");

  a_bad_is_fffd: assert property (@(posedge clk) disable iff (rst)
    out_valid && malformed |-> code_point == REPLACEMENT_CP)
    else $error("malformed result is not the replacement character");
`endif

endmodule
